// ----- rtl/core/dgsp_pkg.sv -----
// shared types and constants for the dense graph shortest path block
package dgsp_pkg;

  // fixed field widths
  localparam int NODE_W      = 7;
  localparam int IN_WEIGHT_W = 16;
  localparam int DIST_W      = 23;
  localparam int CNT_W       = 8;

  // packing of the input word: node_a, node_b, weight, edge_present from bit 0 up
  localparam int A_LSB       = 0;
  localparam int B_LSB       = NODE_W;
  localparam int W_LSB       = 2 * NODE_W;
  localparam int P_BIT       = 2 * NODE_W + IN_WEIGHT_W;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 8'd91;
  localparam logic [DIST_W-1:0] DIST_MAX         = 23'h7F_FFFF;

  // opcode carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WR_AB,
    ST_WR_BA,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_END,
    ST_DONE
  } dgsp_state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic wr_ab;
    logic wr_ba;
    logic init;
    logic scan;
    logic find_clr;
    logic relax;
    logic settle;
    logic res_clr;
    logic res_hit;
    logic out_load;
  } dgsp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic wr_ok;
    logic q_ok;
    logic last;
    logic found;
    logic goal_hit;
    logic out_free;
  } dgsp_status_t;

endpackage

// ----- rtl/core/dgsp_ctrl.sv -----
// controller state machine for the dense graph shortest path block
module dgsp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dgsp_pkg::dgsp_status_t status,
  output dgsp_pkg::dgsp_cmd_t    cmd
);
  import dgsp_pkg::*;

  dgsp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (status.clr_done) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (status.is_query) begin
          state_next = status.q_ok ? ST_INIT : ST_DONE;
        end else begin
          state_next = status.wr_ok ? ST_WR_AB : ST_IDLE;
        end
      end
      ST_WR_AB:     state_next = ST_WR_BA;
      ST_WR_BA:     state_next = ST_IDLE;
      ST_INIT:      state_next = ST_SCAN;
      ST_SCAN:      if (status.last) state_next = ST_SCAN_END;
      ST_SCAN_END:  state_next = ST_PICK;
      ST_PICK: begin
        if (!status.found || status.goal_hit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RELAX;
        end
      end
      ST_RELAX:     if (status.last) state_next = ST_RELAX_END;
      ST_RELAX_END: state_next = ST_SCAN;
      ST_DONE:      if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR:     cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE:    cmd.res_clr = status.is_query;
      ST_WR_AB:     cmd.wr_ab = 1'b1;
      ST_WR_BA:     cmd.wr_ba = 1'b1;
      ST_INIT: begin
        cmd.init     = 1'b1;
        cmd.find_clr = 1'b1;
      end
      ST_SCAN:      cmd.scan = 1'b1;
      ST_SCAN_END:  cmd = '0;
      ST_PICK: begin
        cmd.res_hit = status.goal_hit;
        cmd.settle  = status.found && !status.goal_hit;
      end
      ST_RELAX:     cmd.relax = 1'b1;
      ST_RELAX_END: cmd.find_clr = 1'b1;
      ST_DONE:      cmd.out_load = status.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/dgsp_datapath.sv -----
// datapath: edge store, distance memory, node marks, scan and relax logic, result register
module dgsp_datapath #(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [dgsp_pkg::CNT_W-1:0]         cfg_data,
  input  logic [dgsp_pkg::IN_DATA_W-1:0]     in_data,
  input  logic                               in_user,
  input  dgsp_pkg::dgsp_cmd_t                cmd,
  output dgsp_pkg::dgsp_status_t             status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dgsp_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                               out_user
);
  import dgsp_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int AW = 2 * IW;
  localparam int EDGE_DEPTH = 1 << AW;
  localparam int SW = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int CW = ($clog2(MAX_NODES + 1) > CNT_W) ? $clog2(MAX_NODES + 1) : CNT_W;

  // configuration
  logic [CNT_W-1:0] node_count;
  logic [CW-1:0]    n_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  always_comb begin
    if (node_count == '0) begin
      n_act = CW'(1);
    end else if (CW'(node_count) > CW'(MAX_NODES)) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = CW'(node_count);
    end
  end

  // captured item
  logic              it_op;
  logic [NODE_W-1:0] it_a, it_b;
  logic [SW-1:0]     it_w;
  logic              it_p;
  logic [IW-1:0]     n_m1;
  logic [IW-1:0]     src_idx, goal_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_op <= in_user;
      it_a  <= in_data[A_LSB +: NODE_W];
      it_b  <= in_data[B_LSB +: NODE_W];
      it_w  <= in_data[W_LSB +: SW];
      it_p  <= in_data[P_BIT];
      n_m1  <= IW'(n_act - CW'(1));
    end
  end

  assign src_idx  = IW'(it_a);
  assign goal_idx = IW'(it_b);

  // node counter shared by scan and relax
  logic [IW-1:0] j;

  always_ff @(posedge clk) begin
    if (cmd.scan || cmd.relax) begin
      j <= j + IW'(1);
    end else begin
      j <= '0;
    end
  end

  // clearing pass over the edge store
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // scan and relax pipeline stage
  logic          sv, rv;
  logic [IW-1:0] sj, rj;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
      rv <= 1'b0;
    end else begin
      sv <= cmd.scan;
      rv <= cmd.relax;
    end
  end

  always_ff @(posedge clk) begin
    sj <= j;
    rj <= j;
  end

  // current minimum
  logic              found;
  logic [DIST_W-1:0] best;
  logic [IW-1:0]     best_idx;

  // edge store: present bit over weight
  logic [SW:0]   edge_mem [0:EDGE_DEPTH-1];
  logic [SW:0]   edge_rdata;
  logic          e_we;
  logic [AW-1:0] e_waddr;
  logic [SW:0]   e_wdata;

  assign e_we = cmd.clr || cmd.wr_ab || cmd.wr_ba;

  always_comb begin
    if (cmd.clr) begin
      e_waddr = clr_cnt;
      e_wdata = '0;
    end else begin
      e_waddr = cmd.wr_ab ? {src_idx, goal_idx} : {goal_idx, src_idx};
      e_wdata = {it_p, (it_p ? it_w : SW'(0))};
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    if (cmd.relax) begin
      edge_rdata <= edge_mem[{best_idx, j}];
    end
  end

  // node marks
  logic [MAX_NODES-1:0] reached, settled;

  // relax arithmetic
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] cand;
  logic              upd;
  logic [DIST_W-1:0] dist_rdata;

  assign sum  = {1'b0, best} + (DIST_W + 1)'(edge_rdata[SW-1:0]);
  assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign upd  = rv && edge_rdata[SW] && (!reached[rj] || (cand < dist_rdata));

  // distance memory
  logic [DIST_W-1:0] dist_mem [0:MAX_NODES-1];
  logic              d_we;
  logic [IW-1:0]     d_waddr;
  logic [DIST_W-1:0] d_wdata;

  assign d_we    = cmd.init || upd;
  assign d_waddr = cmd.init ? src_idx : rj;
  assign d_wdata = cmd.init ? '0 : cand;

  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdata;
    end
    if (cmd.scan || cmd.relax) begin
      dist_rdata <= dist_mem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
      settled <= '0;
    end else if (cmd.init) begin
      // only the source starts out reached
      reached <= MAX_NODES'(1) << src_idx;
      settled <= '0;
    end else begin
      if (upd) begin
        reached[rj] <= 1'b1;
      end
      if (cmd.settle) begin
        settled[best_idx] <= 1'b1;
      end
    end
  end

  // minimum search, lowest index wins ties
  logic take;

  assign take = sv && reached[sj] && !settled[sj] && (!found || (dist_rdata < best));

  always_ff @(posedge clk) begin
    if (rst || cmd.find_clr) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= dist_rdata;
      best_idx <= sj;
    end
  end

  // result and output word
  logic [DIST_W-1:0] res_dist;
  logic              res_hit;

  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      res_dist <= '0;
      res_hit  <= 1'b0;
    end else if (cmd.res_hit) begin
      res_dist <= best;
      res_hit  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_DATA_W'(res_dist);
      out_user <= res_hit;
    end
  end

  // status
  assign status.clr_done = &clr_cnt;
  assign status.is_query = (it_op == OP_QUERY);
  assign status.wr_ok    = (CW'(it_a) < CW'(MAX_NODES)) && (CW'(it_b) < CW'(MAX_NODES));
  assign status.q_ok     = (CW'(it_a) < n_act) && (CW'(it_b) < n_act);
  assign status.last     = (j == n_m1);
  assign status.found    = found;
  assign status.goal_hit = found && (best_idx == goal_idx);
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- rtl/core/dense_graph_shortest_path.sv -----
// top level of the dense graph shortest path block
//
// Dense Dijkstra search over an undirected graph kept as an adjacency matrix
// of present bits and weights in hundredths. After reset the edge store is
// swept clear, one entry a cycle, over all 2^(2*ceil(log2 MAX_NODES)) entries
// (16384 at the default of 128 nodes); input words are held off during the
// sweep while node_count writes are taken at any time. A write word
// (tuser = 0) stores or removes an edge in both directions, writing the two
// matrix entries one after the other through the single write port of the
// edge store. A query word (tuser = 1) runs the search over the n nodes in
// use: each round scans the distance memory one node a cycle for the
// cheapest unsettled reached node, then walks its matrix row one neighbor a
// cycle. The search stops as soon as the goal is settled or nothing is left
// to settle. One result word comes back per query, none per write; an
// unreachable goal, or a source or goal outside the nodes in use, gives
// distance 0 with reachable clear. Sums saturate at 8388607.
module dense_graph_shortest_path #(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // node_count register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dgsp_pkg::CNT_W-1:0]      cfg_data,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // node_a [6:0], node_b [13:7], weight [29:14], edge_present [30], zero [31]
  input  logic [dgsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode: 0 write edge, 1 query
  input  logic                            s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // distance [22:0], zero [23]
  output logic [dgsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // reachable
  output logic                            m_axis_tuser
);
  import dgsp_pkg::*;

  dgsp_cmd_t    cmd;
  dgsp_status_t status;

  // register writes must only happen while idle; the block does not enforce this, and the port never stalls
  assign cfg_ready = 1'b1;

  // sequencing: clear sweep, edge writes, scan and relax rounds
  dgsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic, plus the output register that decouples the result
  dgsp_datapath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

// ----- rtl/core/dgsp_checker.sv -----
// port-level checks for the dense graph shortest path block, bound to the top level
module dgsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dgsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import dgsp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // no input taken right after reset, the edge store is being swept
  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during clearing sweep");

  // each accepted word is decoded before another is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accept");

  // unreachable results carry zero distance and the pad bit is zero
  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser || (m_axis_tdata[DIST_W-1:0] == '0)) && !m_axis_tdata[OUT_DATA_W-1])
    else $error("bad result word encoding");

endmodule

bind dense_graph_shortest_path dgsp_checker u_dgsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/dense_graph_shortest_path_tb.sv -----
// self-checking testbench for the dense graph shortest path block
module dense_graph_shortest_path_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dgsp_pkg::*;

  localparam int NODES       = 128;
  localparam int TAIL_CYCLES = 32;
  // clear sweep plus the slowest searches, taken several times over
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
  } path_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_WRITE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // predictor state: adjacency matrix and the node count in force
  bit                    edge_on [NODES*NODES];
  bit [IN_WEIGHT_W-1:0]  edge_len [NODES*NODES];
  logic [CNT_W-1:0]      node_count_q = NODE_COUNT_RESET;

  path_result_t          expected_paths [$];
  int                    mismatches = 0;
  int                    cycle_count = 0;
  int                    stall_pct = 0;
  int                    stall_phase_left = 0;
  int                    sink_hold = 0;
  bit                    calm_tail = 1'b0;

  dense_graph_shortest_path dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // dense dijkstra over the nodes in use, lowest index wins ties
  function automatic path_result_t shortest_path(logic [NODE_W-1:0] src,
                                                 logic [NODE_W-1:0] goal);
    int unsigned  n;
    int unsigned  len [NODES];
    bit           reached [NODES];
    bit           settled [NODES];
    int unsigned  best;
    int unsigned  pick;
    int unsigned  cand;
    int           idx;
    bit           found;
    path_result_t res;
    n = (node_count_q == 0) ? 1 : ((node_count_q > NODES) ? NODES : node_count_q);
    res = '0;
    if (src >= n || goal >= n) return res;
    reached[src] = 1'b1;
    for (int r = 0; r < n; r++) begin
      found = 1'b0;
      best = 0;
      pick = 0;
      for (int j = 0; j < n; j++) begin
        if (!settled[j] && reached[j] && (!found || len[j] < best)) begin
          best = len[j];
          pick = j;
          found = 1'b1;
        end
      end
      if (!found) break;
      settled[pick] = 1'b1;
      for (int j = 0; j < n; j++) begin
        idx = pick * NODES + j;
        if (edge_on[idx]) begin
          cand = len[pick] + edge_len[idx];
          if (cand > DIST_MAX) cand = DIST_MAX;
          if (!reached[j] || cand < len[j]) begin
            len[j] = cand;
            reached[j] = 1'b1;
          end
        end
      end
    end
    if (reached[goal]) begin
      res.distance = DIST_W'(len[goal]);
      res.reachable = 1'b1;
    end
    return res;
  endfunction

  // result checker: each result word against the oldest pending query
  always @(posedge clk) begin
    path_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_paths.size() == 0) begin
        $display("%0t: unexpected result, expected none, got distance %0d reachable %0b",
                 $time, m_axis_tdata[DIST_W-1:0], m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_paths.pop_front();
        if (m_axis_tdata[DIST_W-1:0] !== want.distance) begin
          $display("%0t: distance expected %0d got %0d",
                   $time, want.distance, m_axis_tdata[DIST_W-1:0]);
          mismatches++;
        end
        if (m_axis_tuser !== want.reachable) begin
          $display("%0t: reachable expected %0b got %0b",
                   $time, want.reachable, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // result sink: random stall bursts, with the stall rate redrawn at the start of each phase
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_phase_left = 64;
      stall_pct = $urandom_range(0, 2) * 20;
    end
    stall_phase_left--;
    if (calm_tail) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      sink_hold = $urandom_range(1, 4) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one input word; entered and left at a falling edge, tvalid stays up after
  task automatic send_word(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                           logic [IN_WEIGHT_W-1:0] w, logic present);
    int gap;
    if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, present, w, b, a};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_WRITE) begin
      // undirected: both matrix entries, weight cleared on removal
      edge_on[a * NODES + b]  = present;
      edge_on[b * NODES + a]  = present;
      edge_len[a * NODES + b] = present ? w : '0;
      edge_len[b * NODES + a] = present ? w : '0;
    end else begin
      expected_paths.push_back(shortest_path(a, b));
    end
    @(negedge clk);
  endtask

  task automatic write_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                            logic [IN_WEIGHT_W-1:0] w, logic present);
    send_word(OP_WRITE, a, b, w, present);
  endtask

  // weight and present bits ride along unused on a query
  task automatic query(logic [NODE_W-1:0] src, logic [NODE_W-1:0] goal);
    send_word(OP_QUERY, src, goal, IN_WEIGHT_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // hold the input side until every pending result is back, then let a
  // trailing edge write finish
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_paths.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_node_count(logic [CNT_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    node_count_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset count, nothing stored yet
  task automatic test_empty_graph();
    query(7'd5, 7'd5);
    query(7'd0, 7'd1);
    query(7'd90, 7'd0);
    query(7'd91, 7'd0);
    query(7'd0, 7'd127);
  endtask

  task automatic test_edge_updates();
    write_edge(7'd0, 7'd1, 16'd0, 1'b1);
    query(7'd0, 7'd1);
    write_edge(7'd1, 7'd2, 16'hFFFF, 1'b1);
    query(7'd2, 7'd0);
    write_edge(7'd0, 7'd2, 16'd100, 1'b1);
    query(7'd1, 7'd2);
    // removal given with the endpoints swapped
    write_edge(7'd2, 7'd0, 16'h5A5A, 1'b0);
    query(7'd0, 7'd2);
    write_edge(7'd1, 7'd2, 16'd10, 1'b1);
    query(7'd0, 7'd2);
    write_edge(7'd3, 7'd3, 16'd5, 1'b1);
    write_edge(7'd3, 7'd4, 16'd7, 1'b1);
    query(7'd4, 7'd3);
    // above the count in use, still stored
    write_edge(7'd127, 7'd126, 16'hFFFF, 1'b1);
  endtask

  task automatic test_node_count_limits();
    write_node_count(8'd0);
    query(7'd0, 7'd0);
    query(7'd0, 7'd1);
    write_node_count(8'd255);
    query(7'd126, 7'd127);
    query(7'd0, 7'd127);
    write_node_count(8'd128);
    query(7'd127, 7'd126);
    write_node_count(8'd2);
    query(7'd1, 7'd0);
  endtask

  // mostly edges and queries among the nodes in use, some stray words
  task automatic test_random_traffic(logic [CNT_W-1:0] count, int words);
    int n;
    int pick;
    logic [IN_WEIGHT_W-1:0] w;
    write_node_count(count);
    n = (count == 0) ? 1 : ((count > NODES) ? NODES : count);
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: w = IN_WEIGHT_W'($urandom_range(0, 300));
        1: w = IN_WEIGHT_W'($urandom);
        2: w = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        default: w = IN_WEIGHT_W'($urandom_range(1, 2000));
      endcase
      if (pick < 55) begin
        write_edge(NODE_W'($urandom_range(0, n - 1)), NODE_W'($urandom_range(0, n - 1)), w,
                   $urandom_range(0, 9) != 0);
      end else if (pick < 62) begin
        write_edge(NODE_W'($urandom), NODE_W'($urandom), IN_WEIGHT_W'($urandom),
                   1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        query(NODE_W'($urandom_range(0, n - 1)), NODE_W'($urandom_range(0, n - 1)));
      end else begin
        query(NODE_W'($urandom), NODE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_empty_graph();
    test_edge_updates();
    test_node_count_limits();
    test_random_traffic(8'd6, 20);
    test_random_traffic(8'd16, 22);
    test_random_traffic(CNT_W'($urandom_range(100, 255)), 16);
    test_random_traffic(8'd3, 18);
    calm_tail = 1'b1;
    test_random_traffic(CNT_W'($urandom_range(8, 24)), 24);
    wait_for_results();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
